@@ rtl/core/tkl_pkg.sv @@
// shared types, widths and codes for the keyed top-k leaderboard
`default_nettype none

package tkl_pkg;

    // default geometry
    localparam int TOP_K_DEF      = 16;
    localparam int NUM_TABLES_DEF = 3;

    // fixed field widths of the item channels
    localparam int CMD_W    = 1;
    localparam int LIST_W   = 2;
    localparam int ID_W     = 64;
    localparam int SCORE_W  = 31;
    localparam int RANK_W   = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // operation codes
    localparam logic [CMD_W-1:0] CMD_UPDATE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DECREASE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd3;

    // request item
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [LIST_W-1:0]  list_id;
        logic [ID_W-1:0]    player_id;
        logic [SCORE_W-1:0] new_value;
        logic [RANK_W-1:0]  rank_index;
    } req_t;

    // response item
    typedef struct packed {
        logic [ID_W-1:0]     out_player;
        logic [SCORE_W-1:0]  out_value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
    } rsp_t;

    // one stored table entry
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } entry_t;

endpackage

`default_nettype wire

@@ rtl/core/tkl_entry_ram.sv @@
// entry memory: one write port, one read port with registered read data
`default_nettype none

module tkl_entry_ram #(
    parameter int DEPTH  = tkl_pkg::TOP_K_DEF * tkl_pkg::NUM_TABLES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output tkl_pkg::entry_t       rd_data,
    input  wire logic             wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire tkl_pkg::entry_t  wr_data
);

    tkl_pkg::entry_t entry_mem_reg [DEPTH];
    tkl_pkg::entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem_reg[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= entry_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/top_k_keyed_leaderboard_top.sv @@
// keyed top-k leaderboard: sequencer, fill counts and result register around the entry memory
// query: one read at the requested rank; the request side reopens as the result is presented
// update: the id search reads the filled entries of the table, one read per cycle, and a
//   move up takes one read and write per place moved, before the new entry is written
// one item at a time; a bad table gives its result without touching the memory
// reset clears fill counts and control only; entries past the fill count read as empty
`default_nettype none

module top_k_keyed_leaderboard_top #(
    parameter int TOP_K      = tkl_pkg::TOP_K_DEF,
    parameter int NUM_TABLES = tkl_pkg::NUM_TABLES_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_stall,
    input  wire tkl_pkg::req_t req,
    output logic         rsp_valid,
    input  wire logic    rsp_stall,
    output tkl_pkg::rsp_t rsp
);

    localparam int IDX_W   = $clog2(TOP_K);
    localparam int CNT_W   = $clog2(TOP_K + 1);
    localparam int TBL_W   = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int DEPTH   = NUM_TABLES * TOP_K;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CW      = tkl_pkg::COUNT_W;
    localparam int ID_W    = tkl_pkg::ID_W;
    localparam int SCORE_W = tkl_pkg::SCORE_W;
    localparam int RANK_W  = tkl_pkg::RANK_W;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_DECIDE   = 3'd3;
    localparam logic [2:0] S_SHIFT    = 3'd4;
    localparam logic [2:0] S_WRITE    = 3'd5;
    localparam logic [2:0] S_QWAIT    = 3'd6;
    localparam logic [2:0] S_RESP     = 3'd7;

    logic [2:0] state_reg, state_next;

    // captured item
    logic [tkl_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [TBL_W-1:0]          tbl_reg, tbl_next;
    logic                      tbl_ok_reg, tbl_ok_next;
    logic [ID_W-1:0]           pid_reg, pid_next;
    logic [SCORE_W-1:0]        score_reg, score_next;
    logic [RANK_W-1:0]         rank_reg, rank_next;

    // fill counts per table
    logic [CNT_W-1:0] count_reg [NUM_TABLES];
    logic             cnt_we;
    logic [CNT_W-1:0] cnt_new;
    logic [CNT_W-1:0] cnt_cur;

    // read pipeline tracking
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic             issue_reg, issue_next;
    logic             dv_reg, dv_next;
    logic [IDX_W-1:0] didx_reg, didx_next;

    // search results
    logic               match_reg, match_next;
    logic [IDX_W-1:0]   match_pos_reg, match_pos_next;
    logic [SCORE_W-1:0] match_score_reg, match_score_next;
    logic               lower_reg, lower_next;
    logic [IDX_W-1:0]   lower_pos_reg, lower_pos_next;
    logic [SCORE_W-1:0] last_score_reg, last_score_next;
    logic [IDX_W-1:0]   dest_reg, dest_next;

    // result staging and output register
    tkl_pkg::rsp_t res_reg, res_next;
    tkl_pkg::rsp_t rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    // memory port signals
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic [ADDR_W-1:0] rd_addr;
    tkl_pkg::entry_t   rd_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [ADDR_W-1:0] wr_addr;
    tkl_pkg::entry_t   wr_data;

    logic              accept;
    logic              slot_free;
    logic [ADDR_W-1:0] base;
    logic              full;
    logic [IDX_W-1:0]  upd_pos;
    logic [IDX_W-1:0]  upd_dest;
    logic              rank_ok;
    logic              rank_hit;

    tkl_entry_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // handshake
    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // table base and addresses
    assign base    = ADDR_W'(tbl_reg) * ADDR_W'(TOP_K);
    assign rd_addr = base + ADDR_W'(rd_idx);
    assign wr_addr = base + ADDR_W'(wr_idx);

    // fill count of the addressed table
    assign cnt_cur = tbl_ok_reg ? count_reg[tbl_reg] : '0;

    // placement of an accepted update
    assign full     = (cnt_cur == CNT_W'(TOP_K));
    assign upd_pos  = match_reg ? match_pos_reg :
                      (full ? IDX_W'(TOP_K - 1) : cnt_cur[IDX_W-1:0]);
    assign upd_dest = (lower_reg && (lower_pos_reg < upd_pos)) ? lower_pos_reg : upd_pos;

    // query rank checks
    assign rank_ok  = (rank_reg != '0) && (32'(rank_reg) <= TOP_K);
    assign rank_hit = (32'(rank_reg) <= 32'(cnt_cur));

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        tbl_next         = tbl_reg;
        tbl_ok_next      = tbl_ok_reg;
        pid_next         = pid_reg;
        score_next       = score_reg;
        rank_next        = rank_reg;
        rd_ptr_next      = rd_ptr_reg;
        issue_next       = issue_reg;
        match_next       = match_reg;
        match_pos_next   = match_pos_reg;
        match_score_next = match_score_reg;
        lower_next       = lower_reg;
        lower_pos_next   = lower_pos_reg;
        last_score_next  = last_score_reg;
        dest_next        = dest_reg;
        res_next         = res_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        cnt_we           = 1'b0;
        cnt_new          = cnt_cur;
        rd_en            = 1'b0;
        rd_idx           = '0;
        wr_en            = 1'b0;
        wr_idx           = '0;
        wr_data          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = req.cmd;
                    tbl_next    = TBL_W'(req.list_id);
                    tbl_ok_next = (32'(req.list_id) < NUM_TABLES);
                    pid_next    = req.player_id;
                    score_next  = req.new_value;
                    rank_next   = req.rank_index;
                    state_next  = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                res_next = '0;
                if (!tbl_ok_reg)
                begin
                    res_next.status = (cmd_reg == tkl_pkg::CMD_QUERY) ?
                                      tkl_pkg::ST_RANGE : tkl_pkg::ST_DROPPED;
                    state_next = S_RESP;
                end
                else if (cmd_reg == tkl_pkg::CMD_QUERY)
                begin
                    res_next.entry_count = CW'(cnt_cur);
                    if (rank_ok && rank_hit)
                    begin
                        rd_en      = 1'b1;
                        rd_idx     = IDX_W'(rank_reg - RANK_W'(1));
                        state_next = S_QWAIT;
                    end
                    else
                    begin
                        res_next.status = rank_ok ? tkl_pkg::ST_DONE : tkl_pkg::ST_RANGE;
                        state_next      = S_RESP;
                    end
                end
                else
                begin
                    match_next  = 1'b0;
                    lower_next  = 1'b0;
                    rd_ptr_next = '0;
                    state_next  = (cnt_cur == '0) ? S_DECIDE : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // issue one read per cycle over the filled entries
                if (rd_ptr_reg < cnt_cur)
                begin
                    rd_en       = 1'b1;
                    rd_idx      = rd_ptr_reg[IDX_W-1:0];
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                end
                // look at the entry that came back
                if (dv_reg)
                begin
                    if (!match_reg && (rd_data.id == pid_reg))
                    begin
                        match_next       = 1'b1;
                        match_pos_next   = didx_reg;
                        match_score_next = rd_data.score;
                    end
                    if (!lower_reg && (rd_data.score < score_reg))
                    begin
                        lower_next     = 1'b1;
                        lower_pos_next = didx_reg;
                    end
                    last_score_next = rd_data.score;
                    if (CNT_W'(didx_reg) == (cnt_cur - CNT_W'(1)))
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_DECIDE:
            begin
                res_next             = '0;
                res_next.entry_count = CW'(cnt_cur);
                if (full && (score_reg <= last_score_reg))
                begin
                    res_next.status = tkl_pkg::ST_DROPPED;
                    state_next      = S_RESP;
                end
                else if (match_reg && (score_reg < match_score_reg))
                begin
                    res_next.status = tkl_pkg::ST_DECREASE;
                    state_next      = S_RESP;
                end
                else
                begin
                    cnt_we = 1'b1;
                    if (!match_reg && !full)
                    begin
                        cnt_new = cnt_cur + CNT_W'(1);
                    end
                    res_next.entry_count = CW'(cnt_new);
                    res_next.status      = tkl_pkg::ST_DONE;
                    dest_next            = upd_dest;
                    rd_ptr_next          = CNT_W'(upd_pos - IDX_W'(1));
                    issue_next           = (upd_pos != upd_dest);
                    state_next           = (upd_pos != upd_dest) ? S_SHIFT : S_WRITE;
                end
            end

            S_SHIFT:
            begin
                // read the entries above, the nearest one first
                if (issue_reg)
                begin
                    rd_en  = 1'b1;
                    rd_idx = rd_ptr_reg[IDX_W-1:0];
                    if (rd_ptr_reg[IDX_W-1:0] == dest_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg - CNT_W'(1);
                    end
                end
                // write each one a place lower
                if (dv_reg)
                begin
                    wr_en   = 1'b1;
                    wr_idx  = didx_reg + IDX_W'(1);
                    wr_data = rd_data;
                    if (didx_reg == dest_reg)
                    begin
                        state_next = S_WRITE;
                    end
                end
            end

            S_WRITE:
            begin
                wr_en          = 1'b1;
                wr_idx         = dest_reg;
                wr_data.id     = pid_reg;
                wr_data.score  = score_reg;
                state_next     = S_RESP;
            end

            S_QWAIT:
            begin
                res_next.out_player = rd_data.id;
                res_next.out_value  = rd_data.score;
                res_next.status     = tkl_pkg::ST_DONE;
                state_next          = S_RESP;
            end

            S_RESP:
            begin
                if (slot_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // read pipeline follows the issued reads
    assign dv_next   = rd_en;
    assign didx_next = rd_idx;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            dv_reg        <= 1'b0;
            issue_reg     <= 1'b0;
            for (int i = 0; i < NUM_TABLES; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            dv_reg        <= dv_next;
            issue_reg     <= issue_next;
            if (cnt_we)
            begin
                count_reg[tbl_reg] <= cnt_new;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        tbl_reg         <= tbl_next;
        tbl_ok_reg      <= tbl_ok_next;
        pid_reg         <= pid_next;
        score_reg       <= score_next;
        rank_reg        <= rank_next;
        rd_ptr_reg      <= rd_ptr_next;
        didx_reg        <= didx_next;
        match_reg       <= match_next;
        match_pos_reg   <= match_pos_next;
        match_score_reg <= match_score_next;
        lower_reg       <= lower_next;
        lower_pos_reg   <= lower_pos_next;
        last_score_reg  <= last_score_next;
        dest_reg        <= dest_next;
        res_reg         <= res_next;
        rsp_reg         <= rsp_next;
    end

`ifndef NO_ASSERTIONS
    // memory is written only while moving or placing an entry
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_SHIFT || state_reg == S_WRITE))
        else $error("entry memory written outside shift or write");

    // a new result appears only out of the response state
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_RESP))
        else $error("result raised without passing the response state");

    // fill count stays within the table size while an item is worked on
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (32'(cnt_cur) <= TOP_K))
        else $error("table fill count above table size");

    // while shifting, a read never targets an entry at or below the write
    a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && rd_en && wr_en) |-> (rd_addr < wr_addr))
        else $error("shift read overtook the write pointer");
`endif

endmodule

`default_nettype wire

@@ verif/tb_top_k_keyed_leaderboard_top.sv @@
// self-checking testbench for the keyed top-k leaderboard: directed rows, then random traffic
`default_nettype none

module tb_top_k_keyed_leaderboard_top;

    localparam int K          = tkl_pkg::TOP_K_DEF;
    localparam int TABLES     = tkl_pkg::NUM_TABLES_DEF;
    localparam int ID_W       = tkl_pkg::ID_W;
    localparam int SCORE_W    = tkl_pkg::SCORE_W;
    localparam int RANK_W     = tkl_pkg::RANK_W;
    localparam int LIST_W     = tkl_pkg::LIST_W;
    localparam int COUNT_W    = tkl_pkg::COUNT_W;
    localparam int HALF_CYC   = 6;
    localparam int RAND_ITEMS = 1350;
    localparam int POOL_SIZE  = 20;
    localparam int DRAIN_CYC  = 2 * K + 20;

    // one directed row: the item, and a typed result where it is obvious
    typedef struct packed {
        tkl_pkg::req_t item;
        logic          typed;
        tkl_pkg::rsp_t want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    tkl_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    tkl_pkg::rsp_t rsp;

    // shadow copy of the three ranking tables
    logic [ID_W-1:0]    board_id    [TABLES][K];
    logic [SCORE_W-1:0] board_score [TABLES][K];
    int unsigned        board_fill  [TABLES];

    tkl_pkg::rsp_t   results_due[$];
    plan_row_t       plan[$];
    logic [ID_W-1:0] id_pool[POOL_SIZE];
    int unsigned send_idle_pct = 0;
    int unsigned rcv_stall_pct = 0;
    int unsigned error_count = 0;
    logic [SCORE_W-1:0] drift_level = '0;

    top_k_keyed_leaderboard_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #HALF_CYC clk = ~clk;

    // apply one item to the shadow tables and return the result it gives
    function automatic tkl_pkg::rsp_t rank_result(input tkl_pkg::req_t r);
        tkl_pkg::rsp_t      res;
        int unsigned        t;
        int unsigned        cnt;
        int unsigned        pos;
        int unsigned        i;
        logic               found;
        logic [ID_W-1:0]    tmp_id;
        logic [SCORE_W-1:0] tmp_score;

        res = '0;
        res.status = tkl_pkg::ST_DONE;
        t = 32'(r.list_id);
        if (t >= TABLES)
        begin
            res.status = (r.cmd == tkl_pkg::CMD_QUERY) ? tkl_pkg::ST_RANGE
                                                       : tkl_pkg::ST_DROPPED;
        end
        else if (r.cmd == tkl_pkg::CMD_UPDATE)
        begin
            cnt = board_fill[t];
            if (cnt >= K && r.new_value <= board_score[t][K-1])
            begin
                res.status = tkl_pkg::ST_DROPPED;
            end
            else
            begin
                // search for the id among filled entries
                found = 1'b0;
                pos = 0;
                for (i = 0; i < cnt; i++)
                begin
                    if (!found && board_id[t][i] == r.player_id)
                    begin
                        found = 1'b1;
                        pos = i;
                    end
                end
                if (found && r.new_value < board_score[t][pos])
                begin
                    res.status = tkl_pkg::ST_DECREASE;
                end
                else
                begin
                    if (!found)
                    begin
                        pos = (cnt < K) ? cnt : K - 1;
                        if (cnt < K)
                            cnt++;
                        board_id[t][pos] = r.player_id;
                    end
                    board_score[t][pos] = r.new_value;
                    // move up past strictly lower scores
                    while (pos > 0 && board_score[t][pos-1] < board_score[t][pos])
                    begin
                        tmp_id = board_id[t][pos];
                        tmp_score = board_score[t][pos];
                        board_id[t][pos] = board_id[t][pos-1];
                        board_score[t][pos] = board_score[t][pos-1];
                        board_id[t][pos-1] = tmp_id;
                        board_score[t][pos-1] = tmp_score;
                        pos--;
                    end
                    board_fill[t] = cnt;
                end
            end
            res.entry_count = COUNT_W'(board_fill[t]);
        end
        else
        begin
            if (r.rank_index >= 1 && r.rank_index <= K)
            begin
                res.out_player = board_id[t][r.rank_index-1];
                res.out_value = board_score[t][r.rank_index-1];
            end
            else
            begin
                res.status = tkl_pkg::ST_RANGE;
            end
            res.entry_count = COUNT_W'(board_fill[t]);
        end
        return res;
    endfunction

    // random item, mostly aimed at the three tables with a small id pool
    function automatic tkl_pkg::req_t random_item();
        tkl_pkg::req_t r;
        int unsigned   pick;

        r.cmd = ($urandom_range(99) < 35) ? tkl_pkg::CMD_QUERY : tkl_pkg::CMD_UPDATE;
        r.list_id = ($urandom_range(99) < 5) ? LIST_W'(3)
                                             : LIST_W'($urandom_range(TABLES - 1));
        r.player_id = ($urandom_range(99) < 90) ? id_pool[$urandom_range(POOL_SIZE - 1)]
                                                : {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 40)
            r.new_value = SCORE_W'($urandom_range(63));
        else if (pick < 70)
        begin
            drift_level = drift_level + SCORE_W'(50);
            r.new_value = drift_level + SCORE_W'($urandom_range(255));
        end
        else if (pick < 90)
            r.new_value = SCORE_W'($urandom);
        else
            r.new_value = {SCORE_W{1'b1}} - SCORE_W'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 80)
            r.rank_index = RANK_W'($urandom_range(K, 1));
        else if (pick < 90)
            r.rank_index = ($urandom_range(1) == 0) ? RANK_W'(0)
                                                    : RANK_W'($urandom_range(K + 4, K + 1));
        else
            r.rank_index = RANK_W'($urandom_range(255));
        return r;
    endfunction

    // present one item, then record its result once it is taken
    task automatic send_item(input tkl_pkg::req_t item, input logic typed,
                             input tkl_pkg::rsp_t want);
        int unsigned   gap;
        tkl_pkg::rsp_t calc;

        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        calc = rank_result(item);
        results_due.push_back(typed ? want : calc);
    endtask

    // hold the sender until every result is back
    task automatic drain_results();
        req_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    // result side: random stall and field-by-field check
    always @(posedge clk)
    begin
        tkl_pkg::rsp_t want;
        rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (results_due.size() == 0)
            begin
                $error("result with none expected: player %h value %h status %0d count %0d",
                       rsp.out_player, rsp.out_value, rsp.status, rsp.entry_count);
                error_count++;
            end
            else
            begin
                want = results_due.pop_front();
                if (rsp.out_player !== want.out_player)
                begin
                    $error("out_player expected %h got %h", want.out_player, rsp.out_player);
                    error_count++;
                end
                if (rsp.out_value !== want.out_value)
                begin
                    $error("out_value expected %h got %h", want.out_value, rsp.out_value);
                    error_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status expected %0d got %0d", want.status, rsp.status);
                    error_count++;
                end
                if (rsp.entry_count !== want.entry_count)
                begin
                    $error("entry_count expected %0d got %0d", want.entry_count, rsp.entry_count);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #(2 * HALF_CYC * 800000);
        $display("FAIL");
        $finish;
    end

    // main stimulus
    initial
    begin
        int unsigned   n;
        int unsigned   phase;
        tkl_pkg::req_t item;

        for (int t = 0; t < TABLES; t++)
        begin
            board_fill[t] = 0;
            for (int e = 0; e < K; e++)
            begin
                board_id[t][e] = '0;
                board_score[t][e] = '0;
            end
        end
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = {$urandom, $urandom};

        // empty tables, range limits, bad table, extremes, decrease and ties
        plan.push_back('{'{tkl_pkg::CMD_QUERY, 2'd0, 64'd0, 31'd0, 8'd1}, 1'b1,
                         '{64'd0, 31'd0, tkl_pkg::ST_DONE, 5'd0}});
        plan.push_back('{'{tkl_pkg::CMD_QUERY, 2'd2, 64'd0, 31'd0, 8'd16}, 1'b1,
                         '{64'd0, 31'd0, tkl_pkg::ST_DONE, 5'd0}});
        plan.push_back('{'{tkl_pkg::CMD_QUERY, 2'd0, '1, '1, 8'd0}, 1'b1,
                         '{64'd0, 31'd0, tkl_pkg::ST_RANGE, 5'd0}});
        plan.push_back('{'{tkl_pkg::CMD_QUERY, 2'd1, 64'd0, 31'd0, 8'd17}, 1'b1,
                         '{64'd0, 31'd0, tkl_pkg::ST_RANGE, 5'd0}});
        plan.push_back('{'{tkl_pkg::CMD_QUERY, 2'd1, '1, '1, 8'd255}, 1'b1,
                         '{64'd0, 31'd0, tkl_pkg::ST_RANGE, 5'd0}});
        plan.push_back('{'{tkl_pkg::CMD_QUERY, 2'd3, 64'd0, 31'd0, 8'd1}, 1'b1,
                         '{64'd0, 31'd0, tkl_pkg::ST_RANGE, 5'd0}});
        plan.push_back('{'{tkl_pkg::CMD_UPDATE, 2'd3, '1, '1, '1}, 1'b1,
                         '{64'd0, 31'd0, tkl_pkg::ST_DROPPED, 5'd0}});
        plan.push_back('{'{tkl_pkg::CMD_UPDATE, 2'd0, '1, '1, 8'd0}, 1'b1,
                         '{64'd0, 31'd0, tkl_pkg::ST_DONE, 5'd1}});
        plan.push_back('{'{tkl_pkg::CMD_UPDATE, 2'd0, 64'd0, 31'd0, '1}, 1'b1,
                         '{64'd0, 31'd0, tkl_pkg::ST_DONE, 5'd2}});
        plan.push_back('{'{tkl_pkg::CMD_UPDATE, 2'd0, 64'd5, 31'd100, 8'd0}, 1'b0, '0});
        plan.push_back('{'{tkl_pkg::CMD_UPDATE, 2'd0, 64'd5, 31'd50, 8'd0}, 1'b1,
                         '{64'd0, 31'd0, tkl_pkg::ST_DECREASE, 5'd3}});
        plan.push_back('{'{tkl_pkg::CMD_UPDATE, 2'd0, 64'd5, 31'd100, 8'd0}, 1'b0, '0});
        plan.push_back('{'{tkl_pkg::CMD_UPDATE, 2'd0, 64'd6, 31'd100, 8'd0}, 1'b0, '0});
        plan.push_back('{'{tkl_pkg::CMD_UPDATE, 2'd0, 64'd7, 31'd101, 8'd0}, 1'b0, '0});
        plan.push_back('{'{tkl_pkg::CMD_UPDATE, 2'd0, 64'd0, 31'd100, 8'd0}, 1'b0, '0});
        plan.push_back('{'{tkl_pkg::CMD_QUERY, 2'd0, 64'd0, 31'd0, 8'd1}, 1'b0, '0});
        plan.push_back('{'{tkl_pkg::CMD_QUERY, 2'd0, 64'd0, 31'd0, 8'd2}, 1'b0, '0});
        plan.push_back('{'{tkl_pkg::CMD_QUERY, 2'd0, 64'd0, 31'd0, 8'd3}, 1'b0, '0});
        plan.push_back('{'{tkl_pkg::CMD_QUERY, 2'd0, 64'd0, 31'd0, 8'd4}, 1'b0, '0});
        plan.push_back('{'{tkl_pkg::CMD_QUERY, 2'd0, 64'd0, 31'd0, 8'd5}, 1'b0, '0});
        plan.push_back('{'{tkl_pkg::CMD_QUERY, 2'd0, 64'd0, 31'd0, 8'd16}, 1'b0, '0});
        plan.push_back('{'{tkl_pkg::CMD_QUERY, 2'd0, 64'd0, 31'd0, 8'd6}, 1'b1,
                         '{64'd0, 31'd0, tkl_pkg::ST_DONE, 5'd5}});

        // reset
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        send_idle_pct = 30;
        rcv_stall_pct = 87;
        foreach (plan[i])
            send_item(plan[i].item, plan[i].typed, plan[i].want);
        drain_results();

        // random traffic in three idling phases
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 87 : 0;
            rcv_stall_pct = (phase == 0) ? 87 : (phase == 1) ? 30 : 0;
            for (n = 0; n < RAND_ITEMS / 3; n++)
            begin
                item = random_item();
                send_item(item, 1'b0, '0);
            end
            drain_results();
        end

        // let any stray result show up
        repeat (DRAIN_CYC) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
